// ----- hw/rtl/pmee_pkg.sv -----
// Package for the partition mask edge expander.
// Holds parameter defaults and the control struct passed from the scan
// sequencer to the node store. No dependencies.
`timescale 1ns / 1ps

package pmee_pkg;

	localparam int unsigned PARTITION_NODES_DEF = 64;
	localparam int unsigned MAX_MASK_BYTES_DEF  = 8;
	localparam int unsigned ID_BITS_DEF         = 32;

	// Port widths of the payload fields.
	localparam int unsigned NODE_ID_W   = 32;
	localparam int unsigned MEMBER_W    = 64;
	localparam int unsigned MASK_BYTES_W = 4;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

// ----- hw/rtl/pmee_store.sv -----
// Node store: synchronous memories for the ids and masks of the current partition.
// One write port and one read port, with the read data registered.
// Depends on pmee_pkg.
`timescale 1ns / 1ps

module pmee_store
	import pmee_pkg::*;
#(
	parameter int unsigned PARTITION_NODES = PARTITION_NODES_DEF,
	parameter int unsigned MAX_MASK_BYTES  = MAX_MASK_BYTES_DEF,
	parameter int unsigned ID_BITS         = ID_BITS_DEF
) (
	input  logic                               clk,
	input  store_ctl_t                         ctl,
	input  logic [$clog2(PARTITION_NODES)-1:0] wr_addr,
	input  logic [ID_BITS-1:0]                 wr_id,
	input  logic [8*MAX_MASK_BYTES-1:0]        wr_mask,
	input  logic [$clog2(PARTITION_NODES)-1:0] rd_addr,
	output logic [ID_BITS-1:0]                 rd_id,
	output logic [8*MAX_MASK_BYTES-1:0]        rd_mask
);

	localparam int unsigned MASK_W = 8 * MAX_MASK_BYTES;

	logic [ID_BITS-1:0] id_mem   [PARTITION_NODES];
	logic [MASK_W-1:0]  mask_mem [PARTITION_NODES];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			id_mem[wr_addr]   <= wr_id;
			mask_mem[wr_addr] <= wr_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_id   <= id_mem[rd_addr];
			rd_mask <= mask_mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/pmee_scan.sv -----
// Scan sequencer: accepts a node, writes it to the store if there is room, then walks
// the earlier nodes one read per cycle, emitting each matching pair. Depends on pmee_pkg.
`timescale 1ns / 1ps

module pmee_scan
	import pmee_pkg::*;
#(
	parameter int unsigned PARTITION_NODES = PARTITION_NODES_DEF,
	parameter int unsigned MAX_MASK_BYTES  = MAX_MASK_BYTES_DEF,
	parameter int unsigned ID_BITS         = ID_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [NODE_ID_W-1:0]               node_id,
	input  logic [MEMBER_W-1:0]                member_mask,
	input  logic [MASK_BYTES_W-1:0]            mask_bytes,
	input  logic                               partition_end,
	output store_ctl_t                         ctl,
	output logic [$clog2(PARTITION_NODES)-1:0] wr_addr,
	output logic [ID_BITS-1:0]                 wr_id,
	output logic [8*MAX_MASK_BYTES-1:0]        wr_mask,
	output logic [$clog2(PARTITION_NODES)-1:0] rd_addr,
	input  logic [ID_BITS-1:0]                 rd_id,
	input  logic [8*MAX_MASK_BYTES-1:0]        rd_mask,
	output logic                               result_strobe,
	output logic [NODE_ID_W-1:0]               earlier_node,
	output logic [NODE_ID_W-1:0]               later_node,
	output logic                               last_edge
);

	localparam int unsigned MASK_W = 8 * MAX_MASK_BYTES;
	localparam int unsigned IDX_W  = $clog2(PARTITION_NODES);
	localparam int unsigned CNT_W  = $clog2(PARTITION_NODES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} scan_state_t;

	scan_state_t               state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          n_q;
	logic [CNT_W-1:0]          iss_q;
	logic                      rv_s1;
	logic                      hold_v_q;
	logic                      strobe_q;
	logic [ID_BITS-1:0]        id_q;
	logic [MASK_W-1:0]         mask_q;
	logic                      zero_q;
	logic [ID_BITS-1:0]        hold_id_q;
	logic [ID_BITS-1:0]        earlier_q;
	logic                      last_q;

	logic                      accept;
	logic                      room;
	logic                      issue;
	logic                      hit;
	logic                      done;
	logic [MASK_BYTES_W-1:0]   nb_clamp;
	logic [MASK_W-1:0]         keep;

	assign accept = start && (state_q == ST_IDLE);
	assign room   = (count_q != CNT_W'(PARTITION_NODES));
	assign issue  = (state_q == ST_SCAN) && (iss_q != n_q);
	assign done   = (state_q == ST_SCAN) && (iss_q == n_q) && !rv_s1;
	assign busy   = (state_q != ST_IDLE);

	assign nb_clamp = (mask_bytes > MASK_BYTES_W'(MAX_MASK_BYTES)) ?
		MASK_BYTES_W'(MAX_MASK_BYTES) : mask_bytes;

	always_comb begin
		for (int b = 0; b < MAX_MASK_BYTES; b++) begin
			keep[b*8 +: 8] = {8{MASK_BYTES_W'(b) < nb_clamp}};
		end
	end

	// A zero byte count makes every pair of distinct ids adjacent.
	assign hit = zero_q ? (rd_id != id_q) : (|(rd_mask & mask_q));

	// The new node goes in at the fill index, above every entry the scan reads.
	assign ctl.wr_en = accept && room;
	assign ctl.rd_en = issue;
	assign wr_addr   = count_q[IDX_W-1:0];
	assign wr_id     = node_id[ID_BITS-1:0];
	assign wr_mask   = member_mask[MASK_W-1:0];
	assign rd_addr   = iss_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			n_q      <= '0;
			iss_q    <= '0;
			rv_s1    <= 1'b0;
			hold_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rv_s1    <= issue;
			if (accept) begin
				if (partition_end) begin
					count_q <= '0;
				end else if (room) begin
					count_q <= count_q + 1'b1;
				end
				n_q      <= count_q;
				iss_q    <= '0;
				hold_v_q <= 1'b0;
				if (room && (count_q != '0)) begin
					state_q <= ST_SCAN;
				end
			end
			if (issue) begin
				iss_q <= iss_q + 1'b1;
			end
			// Each match releases the one held before it, so the final match
			// can still be flagged as the last.
			if (rv_s1 && hit) begin
				if (hold_v_q) begin
					strobe_q <= 1'b1;
				end
				hold_v_q <= 1'b1;
			end
			if (done) begin
				strobe_q <= hold_v_q;
				hold_v_q <= 1'b0;
				state_q  <= ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= node_id[ID_BITS-1:0];
			mask_q <= member_mask[MASK_W-1:0] & keep;
			zero_q <= (nb_clamp == '0);
		end
		if (rv_s1 && hit) begin
			hold_id_q <= rd_id;
			earlier_q <= hold_id_q;
			last_q    <= 1'b0;
		end
		if (done) begin
			earlier_q <= hold_id_q;
			last_q    <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign earlier_node  = NODE_ID_W'(earlier_q);
	assign later_node    = NODE_ID_W'(id_q);
	assign last_edge     = last_q;

endmodule

// ----- hw/rtl/partition_mask_edge_expander.sv -----
// Top level of the partition mask edge expander: scan sequencer plus node store.
// Depends on pmee_pkg, pmee_scan and pmee_store.
//
//   Channel   Handshake                 Fields
//   input     start / busy              node_id, member_mask, mask_bytes, partition_end
//   result    result_strobe (no stall)  earlier_node, later_node, last_edge
//
// While a node with earlier nodes in the store is scanned, busy stays high through
// one store read per earlier node, the wait for the last read data and the release
// of the held final edge; no new node is taken until busy falls. When the store is
// empty or full no scan starts and busy stays low. The single store read port paces the scan.
// Results appear one cycle each; the receiver cannot stall them.
// After reset the store is empty; no clearing pass is needed.
`timescale 1ns / 1ps

module partition_mask_edge_expander
	import pmee_pkg::*;
#(
	parameter int unsigned PARTITION_NODES = PARTITION_NODES_DEF,
	parameter int unsigned MAX_MASK_BYTES  = MAX_MASK_BYTES_DEF,
	parameter int unsigned ID_BITS         = ID_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [NODE_ID_W-1:0]    node_id,
	input  logic [MEMBER_W-1:0]     member_mask,
	input  logic [MASK_BYTES_W-1:0] mask_bytes,
	input  logic                    partition_end,
	output logic                    result_strobe,
	output logic [NODE_ID_W-1:0]    earlier_node,
	output logic [NODE_ID_W-1:0]    later_node,
	output logic                    last_edge
);

	localparam int unsigned MASK_W = 8 * MAX_MASK_BYTES;
	localparam int unsigned IDX_W  = $clog2(PARTITION_NODES);

	store_ctl_t         ctl;
	logic [IDX_W-1:0]   wr_addr;
	logic [ID_BITS-1:0] wr_id;
	logic [MASK_W-1:0]  wr_mask;
	logic [IDX_W-1:0]   rd_addr;
	logic [ID_BITS-1:0] rd_id;
	logic [MASK_W-1:0]  rd_mask;

	pmee_scan #(
		.PARTITION_NODES (PARTITION_NODES),
		.MAX_MASK_BYTES  (MAX_MASK_BYTES),
		.ID_BITS         (ID_BITS)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.node_id       (node_id),
		.member_mask   (member_mask),
		.mask_bytes    (mask_bytes),
		.partition_end (partition_end),
		.ctl           (ctl),
		.wr_addr       (wr_addr),
		.wr_id         (wr_id),
		.wr_mask       (wr_mask),
		.rd_addr       (rd_addr),
		.rd_id         (rd_id),
		.rd_mask       (rd_mask),
		.result_strobe (result_strobe),
		.earlier_node  (earlier_node),
		.later_node    (later_node),
		.last_edge     (last_edge)
	);

	pmee_store #(
		.PARTITION_NODES (PARTITION_NODES),
		.MAX_MASK_BYTES  (MAX_MASK_BYTES),
		.ID_BITS         (ID_BITS)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_id   (wr_id),
		.wr_mask (wr_mask),
		.rd_addr (rd_addr),
		.rd_id   (rd_id),
		.rd_mask (rd_mask)
	);

	// An edge that is not the last of its run means the scan is still going.
	a_mid_edge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_edge |-> busy)
		else $error("non-final edge emitted after the scan finished");

	// Results come only out of a scan.
	a_strobe_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result emitted without a preceding scan");

	// The scan only starts from an accepted transaction.
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("scan started without a transaction");

	// The store is never written and read in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_en && ctl.rd_en))
		else $error("store written while a scan read is in flight");

endmodule

// ----- bench/partition_mask_edge_checker.sv -----
`timescale 1ns / 1ps
// Checker for the partition mask edge expander: watches the node and edge channels,
// predicts the edges of every accepted node and compares them in order.
// Depends on pmee_pkg for port widths and the default store dimensions.

module partition_mask_edge_checker
	import pmee_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [NODE_ID_W-1:0]    node_id,
	input  logic [MEMBER_W-1:0]     member_mask,
	input  logic [MASK_BYTES_W-1:0] mask_bytes,
	input  logic                    partition_end,
	input  logic                    result_strobe,
	input  logic [NODE_ID_W-1:0]    earlier_node,
	input  logic [NODE_ID_W-1:0]    later_node,
	input  logic                    last_edge,
	output int                      mismatch_count,
	output int                      edges_pending,
	output int                      nodes_stored,
	output int                      nodes_dropped,
	output int                      edges_checked
);

	localparam int unsigned CAPACITY   = PARTITION_NODES_DEF;
	localparam logic [63:0] ID_KEEP    = (64'd1 << ID_BITS_DEF) - 64'd1;
	localparam int          SHOW_LIMIT = 10;

	typedef struct {
		logic [NODE_ID_W-1:0] earlier;
		logic [NODE_ID_W-1:0] later;
		logic                 last;
	} edge_pair_t;

	logic [NODE_ID_W-1:0] held_ids [CAPACITY];
	logic [MEMBER_W-1:0]  held_masks [CAPACITY];
	int unsigned          held_count = 0;
	edge_pair_t           expected_edges [$];
	int                   mismatches = 0;
	int                   stored_total = 0;
	int                   dropped_total = 0;
	int                   checked_total = 0;

	// Compares a new node with every held node of the partition, queues the edges
	// it makes and then holds the node, unless the store is already full.
	task automatic expand_node(input logic [NODE_ID_W-1:0] id_in,
			input logic [MEMBER_W-1:0] mask_in, input logic [MASK_BYTES_W-1:0] bytes_in,
			input logic end_in);
		logic [NODE_ID_W-1:0] id;
		logic [MEMBER_W-1:0]  keep;
		int unsigned          nbytes;
		int unsigned          first;
		logic                 hit;
		edge_pair_t           pair;
		id = id_in & ID_KEEP[NODE_ID_W-1:0];
		nbytes = (bytes_in > MAX_MASK_BYTES_DEF) ? MAX_MASK_BYTES_DEF : bytes_in;
		keep = (nbytes >= 8) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
		first = expected_edges.size();
		if (held_count < CAPACITY) begin
			for (int unsigned j = 0; j < held_count; j++) begin
				if (nbytes == 0)
					hit = (held_ids[j] != id);
				else
					hit = ((held_masks[j] & mask_in & keep) != '0);
				if (hit) begin
					pair.earlier = held_ids[j];
					pair.later   = id;
					pair.last    = 1'b0;
					expected_edges.insert(expected_edges.size(), pair);
				end
			end
			held_ids[held_count]   = id;
			held_masks[held_count] = mask_in;
			held_count++;
			stored_total++;
		end else begin
			dropped_total++;
		end
		if (expected_edges.size() > first)
			expected_edges[expected_edges.size() - 1].last = 1'b1;
		if (end_in)
			held_count = 0;
	endtask

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= SHOW_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		edge_pair_t want;
		if (!arst_n) begin
			held_count = 0;
			expected_edges.delete();
		end else begin
			if (start && busy === 1'b0)
				expand_node(node_id, member_mask, mask_bytes, partition_end);
			if (result_strobe === 1'b1) begin
				if (expected_edges.size() == 0) begin
					report($sformatf("unexpected edge %h -> %h last %b",
						earlier_node, later_node, last_edge));
				end else begin
					want = expected_edges.pop_front();
					checked_total++;
					if (earlier_node !== want.earlier || later_node !== want.later ||
							last_edge !== want.last)
						report($sformatf("expected %h -> %h last %b, got %h -> %h last %b",
							want.earlier, want.later, want.last,
							earlier_node, later_node, last_edge));
				end
			end
		end
		mismatch_count <= mismatches;
		edges_pending  <= expected_edges.size();
		nodes_stored   <= stored_total;
		nodes_dropped  <= dropped_total;
		edges_checked  <= checked_total;
	end

endmodule

// ----- bench/tb_partition_mask_edge_expander.sv -----
`timescale 1ns / 1ps
// Testbench top for the partition mask edge expander: drives directed and random
// partitions in bursts and gives the verdict. Depends on pmee_pkg, the block and
// partition_mask_edge_checker.

module tb_partition_mask_edge_expander;
	import pmee_pkg::*;

	localparam int NODE_TARGET   = 470;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int FULL_RUNS_MAX = 2;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [NODE_ID_W-1:0]    node_id = '0;
	logic [MEMBER_W-1:0]     member_mask = '0;
	logic [MASK_BYTES_W-1:0] mask_bytes = '0;
	logic                    partition_end = 1'b0;
	logic                    busy;
	logic                    result_strobe;
	logic [NODE_ID_W-1:0]    earlier_node;
	logic [NODE_ID_W-1:0]    later_node;
	logic                    last_edge;

	int mismatch_count;
	int edges_pending;
	int nodes_stored;
	int nodes_dropped;
	int edges_checked;

	int cycle_count = 0;
	int nodes_sent = 0;
	int partitions = 0;
	int full_runs = 0;
	int burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	partition_mask_edge_expander DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.node_id       (node_id),
		.member_mask   (member_mask),
		.mask_bytes    (mask_bytes),
		.partition_end (partition_end),
		.result_strobe (result_strobe),
		.earlier_node  (earlier_node),
		.later_node    (later_node),
		.last_edge     (last_edge)
	);

	partition_mask_edge_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.node_id        (node_id),
		.member_mask    (member_mask),
		.mask_bytes     (mask_bytes),
		.partition_end  (partition_end),
		.result_strobe  (result_strobe),
		.earlier_node   (earlier_node),
		.later_node     (later_node),
		.last_edge      (last_edge),
		.mismatch_count (mismatch_count),
		.edges_pending  (edges_pending),
		.nodes_stored   (nodes_stored),
		.nodes_dropped  (nodes_dropped),
		.edges_checked  (edges_checked)
	);

	// The gap of a finished burst is taken before start is raised again, so start
	// is never lowered and raised within the same step.
	task automatic send_node(input logic [NODE_ID_W-1:0] id, input logic [MEMBER_W-1:0] mask,
			input logic [MASK_BYTES_W-1:0] nbytes, input logic closing);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 12);
		end
		burst_left--;
		start         <= 1'b1;
		node_id       <= id;
		member_mask   <= mask;
		mask_bytes    <= nbytes;
		partition_end <= closing;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		nodes_sent++;
	endtask

	task automatic send_partition(input int unsigned size);
		logic [NODE_ID_W-1:0]    ids_so_far [$];
		logic [NODE_ID_W-1:0]    id;
		logic [MEMBER_W-1:0]     mask;
		logic [MASK_BYTES_W-1:0] part_bytes;
		logic [MASK_BYTES_W-1:0] nbytes;
		logic                    closing;
		int unsigned             span;
		part_bytes = ($urandom_range(0, 9) == 0) ? MASK_BYTES_W'($urandom_range(9, 15)) :
			MASK_BYTES_W'($urandom_range(0, 8));
		for (int unsigned n = 0; n < size; n++) begin
			nbytes = ($urandom_range(0, 6) == 0) ? MASK_BYTES_W'($urandom_range(0, 15)) :
				part_bytes;
			if (ids_so_far.size() > 0 && $urandom_range(0, 3) == 0)
				id = ids_so_far[$urandom_range(0, ids_so_far.size() - 1)];
			else if ($urandom_range(0, 3) == 0)
				id = $urandom_range(0, 15);
			else
				id = $urandom;
			// Sparse masks mostly land inside the bytes that count, so edges stay
			// neither certain nor rare.
			span = (nbytes == 0 || nbytes > 8) ? 64 : 8 * nbytes;
			case ($urandom_range(0, 4))
				0: mask = {$urandom, $urandom};
				1: mask = '0;
				default: mask = (64'd1 << $urandom_range(0, span - 1)) |
					(64'd1 << $urandom_range(0, 63));
			endcase
			if (n == size - 1)
				closing = ($urandom_range(0, 9) != 0);
			else
				closing = ($urandom_range(0, 24) == 0);
			ids_so_far.insert(ids_so_far.size(), id);
			send_node(id, mask, nbytes, closing);
		end
		partitions++;
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d edges outstanding", cycle_count, edges_pending);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// All pairs by distinct ids, then masks with the oversized byte count.
		send_node(32'h0000_0000, 64'h0, 4'd0, 1'b0);
		send_node(32'hFFFF_FFFF, '1, 4'd0, 1'b0);
		send_node(32'h0000_0000, '1, 4'd0, 1'b0);
		send_node(32'h0000_0005, '1, 4'd8, 1'b0);
		send_node(32'h0000_0005, 64'h8000_0000_0000_0000, 4'd15, 1'b1);
		// Byte counts that cut the masks, equal ids joined by a shared bit and nodes
		// that make no edge at all.
		send_node(32'h0000_0007, 64'h0000_0000_0000_FF01, 4'd1, 1'b0);
		send_node(32'h0000_0007, 64'h0000_0000_0000_0001, 4'd1, 1'b0);
		send_node(32'h0000_0009, 64'h0000_0000_0000_FF00, 4'd1, 1'b0);
		send_node(32'h0000_0009, 64'h0000_0000_0000_FF00, 4'd2, 1'b0);
		send_node(32'h0000_000A, 64'hFF00_0000_0000_0000, 4'd7, 1'b0);
		send_node(32'h0000_000B, 64'h8000_0000_0000_0000, 4'd8, 1'b0);
		send_node(32'h0000_000B, 64'h0, 4'd9, 1'b0);
		send_node(32'h0000_000C, 64'h0, 4'd0, 1'b1);
		send_node(32'h0000_0003, 64'h0, 4'd0, 1'b1);
		send_node(32'hDEAD_BEEF, 64'hAAAA_AAAA_AAAA_AAAA, 4'd4, 1'b0);
		send_node(32'hDEAD_BEEF, 64'h5555_5555_5555_5555, 4'd4, 1'b0);
		send_node(32'h1234_5678, 64'h0000_0001_0000_0000, 4'd4, 1'b1);
		partitions += 4;

		// Mostly short partitions; a couple overfill the store so that late nodes drop.
		while (nodes_sent < NODE_TARGET) begin
			if (full_runs < FULL_RUNS_MAX && partitions % 15 == 7) begin
				full_runs++;
				send_partition(PARTITION_NODES_DEF + $urandom_range(1, 4));
			end else begin
				send_partition($urandom_range(1, 12));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (edges_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d nodes in %0d partitions, %0d of them overfilling the store:",
			nodes_sent, partitions, full_runs);
		$display("%0d nodes stored, %0d dropped, %0d edges checked, %0d mismatches.",
			nodes_stored, nodes_dropped, edges_checked, mismatch_count);
		if (mismatch_count == 0 && edges_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
